/* rtl/core/limit_order_book_bbo_assert.svh */
// Assertion macros for the limit order book top-of-book block.
`ifndef LIMIT_ORDER_BOOK_BBO_ASSERT_SVH
`define LIMIT_ORDER_BOOK_BBO_ASSERT_SVH
`ifndef ASSERT_OFF
// Implication checked at every clock edge outside reset.
`define LOBB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define LOBB_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define LOBB_ASSERT(lbl, clk, rstn, prop, msg)
`define LOBB_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

/* rtl/core/lobb_pkg.sv */
// Types, constants and codes shared by the order book modules.
package lobb_pkg;

  localparam int ORDER_IDS    = 4096;
  localparam int PRICE_LEVELS = 4096;
  localparam int QTY_BITS     = 32;
  localparam int TOTAL_W      = 44;

  localparam int ID_W    = $clog2(ORDER_IDS);
  localparam int PRICE_W = $clog2(PRICE_LEVELS);
  localparam int CNT_W   = $clog2(ORDER_IDS + 1);
  localparam int MAP_W   = 64;
  localparam int COL_W   = $clog2(MAP_W);
  localparam int ROW_W   = PRICE_W - COL_W;
  localparam int LVL_AW  = PRICE_W + 1;
  localparam int MAP_AW  = ROW_W + 1;

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_MOD = 3'd1;
  localparam logic [2:0] MODE_CAN = 3'd2;
  localparam logic [2:0] MODE_DEL = 3'd3;
  localparam logic [2:0] MODE_CLR = 3'd4;

  typedef struct packed {
    logic                valid;
    logic                side;
    logic [PRICE_W-1:0]  price;
    logic [QTY_BITS-1:0] qty;
  } order_t;

  typedef struct packed {
    logic [CNT_W-1:0]   cnt;
    logic [TOTAL_W-1:0] sum;
  } level_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_ORD,
    ST_REM_WR,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_MOD_WR,
    ST_RS_ROW,
    ST_RS_COL,
    ST_OUT_A,
    ST_OUT_B,
    ST_OUT_C
  } state_e;

endpackage

/* rtl/core/lobb_prio.sv */
// Priority encoder over one occupancy word: highest or lowest set bit.
module lobb_prio (
  input  logic [lobb_pkg::MAP_W-1:0] vec_i,
  input  logic                       low_i,
  output logic                       found_o,
  output logic [lobb_pkg::COL_W-1:0] idx_o
);

  always_comb begin
    logic [lobb_pkg::COL_W-1:0] j;
    idx_o = '0;
    j     = '0;
    for (int i = 0; i < lobb_pkg::MAP_W; i++) begin
      // ascending scan keeps the last hit: highest; descending gives lowest
      j = low_i ? lobb_pkg::COL_W'(lobb_pkg::MAP_W - 1 - i) : lobb_pkg::COL_W'(i);
      if (vec_i[j]) begin
        idx_o = j;
      end
    end
  end

  assign found_o = |vec_i;

endmodule

/* rtl/core/limit_order_book_bbo.sv */
// Limit order book with best bid / best ask reporting after every update.
//
// Input channel (in_valid_i / in_ready_o) carries one market update per beat:
// mode (add, modify, cancel, delete, clear, other = no change), order id,
// side, price level and quantity. Output channel (out_valid_o / out_ready_i)
// returns one beat per update: best bid and best ask with the summed quantity
// at each, plus whether the order id was live before the update.
// One update is worked at a time through one-read, one-write tables (order
// table, level table, occupancy words) under a small sequencer: order lookup,
//   then table writes by mode (an add over a live id first removes the old
//   order), then the best bid and ask level reads; when the removed level
//   was the best, a two-step scan (row summary, then word) finds the next.
// The steps follow from the registered table reads, one per step.
// Clear sweeps every table, one address a cycle, then returns the beat.
// After reset the same sweep runs with in_ready_o low.
// A result waits in the output register while the receiver stalls; the next
// update is taken meanwhile and holds in its last step until the register
// frees up.
`include "limit_order_book_bbo_assert.svh"

module limit_order_book_bbo (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  in_mode_i,
  input  logic [11:0] in_order_id_i,
  input  logic        in_side_i,
  input  logic [11:0] in_price_i,
  input  logic [31:0] in_qty_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        out_bid_valid_o,
  output logic [11:0] out_bid_price_o,
  output logic [43:0] out_bid_total_o,
  output logic        out_ask_valid_o,
  output logic [11:0] out_ask_price_o,
  output logic [43:0] out_ask_total_o,
  output logic        out_id_found_o
);

  localparam int IdW   = lobb_pkg::ID_W;
  localparam int PrW   = lobb_pkg::PRICE_W;
  localparam int ColW  = lobb_pkg::COL_W;
  localparam int RowW  = lobb_pkg::ROW_W;
  localparam int MapW  = lobb_pkg::MAP_W;
  localparam int LvlAw = lobb_pkg::LVL_AW;
  localparam int MapAw = lobb_pkg::MAP_AW;
  localparam int TotW  = lobb_pkg::TOTAL_W;
  localparam int CntW  = lobb_pkg::CNT_W;
  localparam int QtyW  = lobb_pkg::QTY_BITS;

  // tables
  lobb_pkg::order_t ord_mem [1 << IdW];
  lobb_pkg::level_t lvl_mem [1 << LvlAw];
  logic [MapW-1:0]  map_mem [1 << MapAw];

  lobb_pkg::order_t ord_rdata_q, ord_wdata;
  lobb_pkg::level_t lvl_rdata_q, lvl_wdata;
  logic [MapW-1:0]  map_rdata_q, map_wdata;
  logic [IdW-1:0]   ord_raddr, ord_waddr;
  logic [LvlAw-1:0] lvl_raddr, lvl_waddr;
  logic [MapAw-1:0] map_raddr, map_waddr;
  logic             ord_we, lvl_we, map_we;

  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    ord_rdata_q <= ord_mem[ord_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (lvl_we) begin
      lvl_mem[lvl_waddr] <= lvl_wdata;
    end
    lvl_rdata_q <= lvl_mem[lvl_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_rdata_q <= map_mem[map_raddr];
  end

  // control and item state
  lobb_pkg::state_e state_q, state_d;
  logic [LvlAw-1:0] clr_cnt_q, clr_cnt_d;
  logic             clr_out_q, clr_out_d;
  logic             add_pend_q, add_pend_d;
  logic [1:0]       best_vld_q, best_vld_d;
  logic [1:0][PrW-1:0]  best_prc_q, best_prc_d;
  logic [1:0][MapW-1:0] summary_q, summary_d;
  logic             out_valid_q, out_valid_d;

  logic [2:0]       mode_q;
  logic [IdW-1:0]   id_q;
  logic             side_q;
  logic [PrW-1:0]   price_q;
  logic [QtyW-1:0]  qty_q;
  logic             found_q;
  lobb_pkg::order_t old_q;
  logic [RowW-1:0]  rs_row_q, rs_row_d;
  logic [TotW-1:0]  bid_sum_q, bid_sum_d;

  logic             out_load;
  logic             in_acc;

  // shared priority encoder: row summary first, then the selected word
  logic [MapW-1:0]  prio_vec;
  logic             prio_found;
  logic [ColW-1:0]  prio_idx;

  assign prio_vec = (state_q == lobb_pkg::ST_RS_ROW) ? summary_q[old_q.side] : map_rdata_q;

  lobb_prio u_prio (
    .vec_i   (prio_vec),
    .low_i   (old_q.side),
    .found_o (prio_found),
    .idx_o   (prio_idx)
  );

  assign in_ready_o = (state_q == lobb_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    logic [CntW-1:0]  ncnt;
    logic [TotW-1:0]  nsum;
    logic [MapW-1:0]  nrow;
    logic [QtyW-1:0]  nq;
    logic             s;
    logic [PrW-1:0]   p;
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    clr_out_d  = clr_out_q;
    add_pend_d = add_pend_q;
    best_vld_d = best_vld_q;
    best_prc_d = best_prc_q;
    summary_d  = summary_q;
    rs_row_d   = rs_row_q;
    bid_sum_d  = bid_sum_q;
    out_load   = 1'b0;
    ord_raddr  = in_order_id_i;
    lvl_raddr  = {old_q.side, old_q.price};
    map_raddr  = {old_q.side, old_q.price[PrW-1 -: RowW]};
    ord_we     = 1'b0;
    ord_waddr  = id_q;
    ord_wdata  = '0;
    lvl_we     = 1'b0;
    lvl_waddr  = {old_q.side, old_q.price};
    lvl_wdata  = '0;
    map_we     = 1'b0;
    map_waddr  = {old_q.side, old_q.price[PrW-1 -: RowW]};
    map_wdata  = '0;
    ncnt       = '0;
    nsum       = '0;
    nrow       = '0;
    nq         = '0;
    s          = old_q.side;
    p          = old_q.price;

    case (state_q)
      lobb_pkg::ST_CLR: begin
        ord_we     = 1'b1;
        ord_waddr  = clr_cnt_q[IdW-1:0];
        lvl_we     = 1'b1;
        lvl_waddr  = clr_cnt_q;
        map_we     = 1'b1;
        map_waddr  = clr_cnt_q[MapAw-1:0];
        best_vld_d = '0;
        best_prc_d = '0;
        summary_d  = '0;
        clr_cnt_d  = clr_cnt_q + LvlAw'(1);
        if (&clr_cnt_q) begin
          state_d   = clr_out_q ? lobb_pkg::ST_OUT_A : lobb_pkg::ST_IDLE;
          clr_out_d = 1'b0;
        end
      end

      lobb_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = lobb_pkg::ST_ORD;
        end
      end

      lobb_pkg::ST_ORD: begin
        ord_raddr  = id_q;
        add_pend_d = 1'b0;
        lvl_raddr  = {ord_rdata_q.side, ord_rdata_q.price};
        map_raddr  = {ord_rdata_q.side, ord_rdata_q.price[PrW-1 -: RowW]};
        case (mode_q)
          lobb_pkg::MODE_ADD: begin
            if (ord_rdata_q.valid) begin
              add_pend_d = 1'b1;
              state_d    = lobb_pkg::ST_REM_WR;
            end else begin
              lvl_raddr = {side_q, price_q};
              map_raddr = {side_q, price_q[PrW-1 -: RowW]};
              state_d   = lobb_pkg::ST_ADD_WR;
            end
          end
          lobb_pkg::MODE_MOD, lobb_pkg::MODE_CAN: begin
            state_d = ord_rdata_q.valid ? lobb_pkg::ST_MOD_WR : lobb_pkg::ST_OUT_A;
          end
          lobb_pkg::MODE_DEL: begin
            state_d = ord_rdata_q.valid ? lobb_pkg::ST_REM_WR : lobb_pkg::ST_OUT_A;
          end
          lobb_pkg::MODE_CLR: begin
            clr_cnt_d = '0;
            clr_out_d = 1'b1;
            state_d   = lobb_pkg::ST_CLR;
          end
          default: begin
            state_d = lobb_pkg::ST_OUT_A;
          end
        endcase
      end

      lobb_pkg::ST_REM_WR: begin
        ncnt = lvl_rdata_q.cnt - CntW'(lvl_rdata_q.cnt != '0);
        nsum = (ncnt == '0) ? '0 : lvl_rdata_q.sum - TotW'(old_q.qty);
        lvl_we    = 1'b1;
        lvl_wdata = '{cnt: ncnt, sum: nsum};
        ord_we    = 1'b1;
        state_d   = add_pend_q ? lobb_pkg::ST_ADD_RD : lobb_pkg::ST_OUT_A;
        if (ncnt == '0) begin
          nrow = map_rdata_q;
          nrow[p[ColW-1:0]] = 1'b0;
          map_we    = 1'b1;
          map_wdata = nrow;
          summary_d[s][p[PrW-1 -: RowW]] = |nrow;
          if (best_vld_q[s] && (best_prc_q[s] == p)) begin
            state_d = lobb_pkg::ST_RS_ROW;
          end
        end
      end

      lobb_pkg::ST_RS_ROW: begin
        if (prio_found) begin
          rs_row_d  = prio_idx[RowW-1:0];
          map_raddr = {s, prio_idx[RowW-1:0]};
          state_d   = lobb_pkg::ST_RS_COL;
        end else begin
          best_vld_d[s] = 1'b0;
          best_prc_d[s] = '0;
          state_d       = add_pend_q ? lobb_pkg::ST_ADD_RD : lobb_pkg::ST_OUT_A;
        end
      end

      lobb_pkg::ST_RS_COL: begin
        best_vld_d[s] = 1'b1;
        best_prc_d[s] = {rs_row_q, prio_idx};
        state_d       = add_pend_q ? lobb_pkg::ST_ADD_RD : lobb_pkg::ST_OUT_A;
      end

      lobb_pkg::ST_ADD_RD: begin
        lvl_raddr = {side_q, price_q};
        map_raddr = {side_q, price_q[PrW-1 -: RowW]};
        state_d   = lobb_pkg::ST_ADD_WR;
      end

      lobb_pkg::ST_ADD_WR: begin
        lvl_we    = 1'b1;
        lvl_waddr = {side_q, price_q};
        lvl_wdata = '{cnt: lvl_rdata_q.cnt + CntW'(1),
                      sum: lvl_rdata_q.sum + TotW'(qty_q)};
        ord_we    = 1'b1;
        ord_wdata = '{valid: 1'b1, side: side_q, price: price_q, qty: qty_q};
        if (lvl_rdata_q.cnt == '0) begin
          nrow = map_rdata_q;
          nrow[price_q[ColW-1:0]] = 1'b1;
          map_we    = 1'b1;
          map_waddr = {side_q, price_q[PrW-1 -: RowW]};
          map_wdata = nrow;
          summary_d[side_q][price_q[PrW-1 -: RowW]] = 1'b1;
          if (!best_vld_q[side_q] ||
              (side_q ? (price_q < best_prc_q[side_q]) : (price_q > best_prc_q[side_q]))) begin
            best_vld_d[side_q] = 1'b1;
            best_prc_d[side_q] = price_q;
          end
        end
        state_d = lobb_pkg::ST_OUT_A;
      end

      lobb_pkg::ST_MOD_WR: begin
        if (mode_q == lobb_pkg::MODE_MOD) begin
          nq = qty_q;
        end else begin
          nq = (old_q.qty > qty_q) ? (old_q.qty - qty_q) : '0;
        end
        lvl_we    = 1'b1;
        lvl_wdata = '{cnt: lvl_rdata_q.cnt,
                      sum: lvl_rdata_q.sum - TotW'(old_q.qty) + TotW'(nq)};
        ord_we    = 1'b1;
        ord_wdata = '{valid: 1'b1, side: old_q.side, price: old_q.price, qty: nq};
        state_d   = lobb_pkg::ST_OUT_A;
      end

      lobb_pkg::ST_OUT_A: begin
        lvl_raddr = {1'b0, best_prc_q[0]};
        state_d   = lobb_pkg::ST_OUT_B;
      end

      lobb_pkg::ST_OUT_B: begin
        bid_sum_d = lvl_rdata_q.sum;
        lvl_raddr = {1'b1, best_prc_q[1]};
        state_d   = lobb_pkg::ST_OUT_C;
      end

      lobb_pkg::ST_OUT_C: begin
        lvl_raddr = {1'b1, best_prc_q[1]};
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = lobb_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = lobb_pkg::ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lobb_pkg::ST_CLR;
      clr_cnt_q   <= '0;
      clr_out_q   <= 1'b0;
      add_pend_q  <= 1'b0;
      best_vld_q  <= '0;
      best_prc_q  <= '0;
      summary_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_out_q   <= clr_out_d;
      add_pend_q  <= add_pend_d;
      best_vld_q  <= best_vld_d;
      best_prc_q  <= best_prc_d;
      summary_q   <= summary_d;
      out_valid_q <= out_valid_d;
    end
  end

  // item and scratch registers: no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q  <= in_mode_i;
      id_q    <= in_order_id_i;
      side_q  <= in_side_i;
      price_q <= in_price_i;
      qty_q   <= in_qty_i;
    end
    if (state_q == lobb_pkg::ST_ORD) begin
      found_q <= ord_rdata_q.valid;
      old_q   <= ord_rdata_q;
    end
    rs_row_q  <= rs_row_d;
    bid_sum_q <= bid_sum_d;
    if (out_load) begin
      out_bid_valid_o <= best_vld_q[0];
      out_bid_price_o <= best_vld_q[0] ? best_prc_q[0] : '0;
      out_bid_total_o <= best_vld_q[0] ? bid_sum_q : '0;
      out_ask_valid_o <= best_vld_q[1];
      out_ask_price_o <= best_vld_q[1] ? best_prc_q[1] : '0;
      out_ask_total_o <= best_vld_q[1] ? lvl_rdata_q.sum : '0;
      out_id_found_o  <= (mode_q == lobb_pkg::MODE_CLR) ? found_q : found_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // an accepted beat always starts with the order table lookup
  `LOBB_ASSERT(a_acc_to_ord, clk_i, rst_ni, in_acc |=> (state_q == lobb_pkg::ST_ORD), "accept did not start lookup")
  // no beat is taken while the tables are being swept
  `LOBB_NEVER(a_no_acc_in_clr, clk_i, rst_ni, (state_q == lobb_pkg::ST_CLR) && in_ready_o, "ready during sweep")
  // at rest, a valid best bid points into an occupied row
  `LOBB_ASSERT(a_bid_row_occ, clk_i, rst_ni, ((state_q == lobb_pkg::ST_IDLE) && best_vld_q[0]) |-> summary_q[0][best_prc_q[0][PrW-1 -: RowW]], "best bid row empty")

endmodule
